### src/nopt_pkg.sv
package nopt_pkg;

  localparam int NOPT_DEPTH = 64;
  localparam int POS_W      = 40;

  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;  // clear the valid bit at the slot address
    logic load;    // capture the item, reset the scan results
    logic rd;      // read the slot at the slot address
    logic commit;  // apply the update, load the result register
  } cmd_t;

endpackage

### src/nopt_ctrl.sv
module nopt_ctrl import nopt_pkg::*; #(
  parameter int DEPTH = NOPT_DEPTH,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cmd_t          cmd,
  output logic [IW-1:0] addr
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [2:0]    state, state_next;
  logic [IW-1:0] cnt, cnt_next;
  logic          out_valid_next;

  assign addr     = cnt;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd   = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == LAST) |=> state == S_DRAIN)
    else $error("scan did not end after the last slot");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

endmodule

### src/nopt_datapath.sv
module nopt_datapath import nopt_pkg::*; #(
  parameter int DEPTH = NOPT_DEPTH,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [IW-1:0]    addr,
  input  logic [1:0]       mode,
  input  logic [POS_W-1:0] position,
  output logic [1:0]       status,
  output logic [POS_W-1:0] nearest
);

  logic             valid_mem [DEPTH];
  logic [POS_W-1:0] pos_mem   [DEPTH];

  logic [1:0]       mode_q;
  logic [POS_W-1:0] pos_q;
  logic             rd_pend;
  logic [IW-1:0]    rd_idx;
  logic             vld_rd;
  logic [POS_W-1:0] pos_rd;

  logic             hit, free_ok, have_lo, have_hi;
  logic [IW-1:0]    hit_idx, free_idx;
  logic [POS_W-1:0] lo, hi;

  logic             ge;
  logic [POS_W-1:0] d_hi, d_lo;
  logic             wr_vld, wr_vld_data, wr_pos;
  logic [IW-1:0]    wr_addr;
  logic [1:0]       status_next;
  logic [POS_W-1:0] nearest_next;

  assign ge   = (pos_rd >= pos_q);
  assign d_hi = hi - pos_q;
  assign d_lo = pos_q - lo;

  // Resolve the operation from the scan results.
  always_comb begin
    wr_vld       = 1'b0;
    wr_vld_data  = 1'b0;
    wr_pos       = 1'b0;
    wr_addr      = free_idx;
    status_next  = ST_DONE;
    nearest_next = '0;
    case (mode_q)
      MODE_OPEN: begin
        if (!hit) begin
          if (free_ok) begin
            wr_vld      = 1'b1;
            wr_vld_data = 1'b1;
            wr_pos      = 1'b1;
          end else begin
            status_next = ST_FULL;
          end
        end
      end
      MODE_CLOSE: begin
        wr_addr = hit_idx;
        wr_vld  = hit;
      end
      MODE_QUERY: begin
        if (!have_lo && !have_hi) begin
          status_next = ST_NONE;
        end else begin
          status_next = ST_FOUND;
          if (!have_lo) begin
            nearest_next = hi;
          end else if (!have_hi) begin
            nearest_next = lo;
          end else begin
            nearest_next = (d_hi > d_lo) ? lo : hi;
          end
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      valid_mem[addr] <= 1'b0;
    end else if (cmd.commit && wr_vld) begin
      valid_mem[wr_addr] <= wr_vld_data;
    end
    if (cmd.commit && wr_pos) begin
      pos_mem[wr_addr] <= pos_q;
    end
    if (cmd.rd) begin
      vld_rd <= valid_mem[addr];
      pos_rd <= pos_mem[addr];
    end
  end

  // Scan accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      have_lo <= 1'b0;
      have_hi <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
      if (cmd.load) begin
        hit     <= 1'b0;
        free_ok <= 1'b0;
        have_lo <= 1'b0;
        have_hi <= 1'b0;
      end else if (rd_pend) begin
        if (vld_rd) begin
          if (pos_rd == pos_q && !hit) begin
            hit <= 1'b1;
          end
          if (ge && (!have_hi || pos_rd < hi)) begin
            have_hi <= 1'b1;
          end
          if (!ge && (!have_lo || pos_rd > lo)) begin
            have_lo <= 1'b1;
          end
        end else if (!free_ok) begin
          free_ok <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_idx <= addr;
    end
    if (cmd.load) begin
      mode_q <= mode;
      pos_q  <= position;
    end else if (rd_pend) begin
      if (vld_rd) begin
        if (pos_rd == pos_q && !hit) begin
          hit_idx <= rd_idx;
        end
        if (ge && (!have_hi || pos_rd < hi)) begin
          hi <= pos_rd;
        end
        if (!ge && (!have_lo || pos_rd > lo)) begin
          lo <= pos_rd;
        end
      end else if (!free_ok) begin
        free_idx <= rd_idx;
      end
    end
    if (cmd.commit) begin
      status  <= status_next;
      nearest <= nearest_next;
    end
  end

  a_lo_below: assert property (@(posedge clk) disable iff (rst)
    have_lo |-> lo < pos_q)
    else $error("predecessor not below the asked position");

  a_hi_above: assert property (@(posedge clk) disable iff (rst)
    have_hi |-> hi >= pos_q)
    else $error("successor below the asked position");

  a_hit_hi: assert property (@(posedge clk) disable iff (rst)
    hit |-> have_hi)
    else $error("match found without a successor");

endmodule

### src/nearest_open_position_table_unit.sv
// Each item scans every slot once through the single read port of the slot
//   memory; a new item is taken only after the last one is committed.
// The result register frees the input side while a result waits.
// Reset: synchronous, active high; a clearing pass then sweeps the valid
//   bits, with in_ready low until it is done.
module nearest_open_position_table_unit import nopt_pkg::*; #(
  parameter int DEPTH = NOPT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic [POS_W-1:0] position,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [POS_W-1:0] nearest
);

  localparam int IW = $clog2(DEPTH);

  cmd_t          cmd;
  logic [IW-1:0] addr;

  // Sequence clear, scan, drain and commit; own both handshakes.
  nopt_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Hold the slot memories, track duplicate, free slot and the nearest
  // candidates on each side during the scan, then register the result.
  nopt_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .addr    (addr),
    .mode    (mode),
    .position(position),
    .status  (status),
    .nearest (nearest)
  );

endmodule
